>>> src/jsv_pkg.sv
// jsv_pkg: shared constants, codes, types and helper functions for the
// json stream validator; no dependencies
package jsv_pkg;

  localparam int MAX_DEPTH   = 32;
  localparam int STACK_SLOTS = MAX_DEPTH + 1;
  localparam int MAX_RES     = 4;

  // parse modes
  localparam logic [4:0] M_VALUE     = 5'd0;
  localparam logic [4:0] M_AFTER     = 5'd1;
  localparam logic [4:0] M_OBJ_FIRST = 5'd2;
  localparam logic [4:0] M_OBJ_KEY   = 5'd3;
  localparam logic [4:0] M_COLON     = 5'd4;
  localparam logic [4:0] M_ARR_FIRST = 5'd5;
  localparam logic [4:0] M_STR       = 5'd6;
  localparam logic [4:0] M_ESC       = 5'd7;
  localparam logic [4:0] M_HEX_HI    = 5'd8;
  localparam logic [4:0] M_LOW_BS    = 5'd9;
  localparam logic [4:0] M_LOW_U     = 5'd10;
  localparam logic [4:0] M_HEX_LO    = 5'd11;
  localparam logic [4:0] M_N_SIGN    = 5'd12;
  localparam logic [4:0] M_N_ZERO    = 5'd13;
  localparam logic [4:0] M_N_INT     = 5'd14;
  localparam logic [4:0] M_N_FRAC0   = 5'd15;
  localparam logic [4:0] M_N_FRAC    = 5'd16;
  localparam logic [4:0] M_N_EXP0    = 5'd17;
  localparam logic [4:0] M_N_EXPS    = 5'd18;
  localparam logic [4:0] M_N_EXP     = 5'd19;
  localparam logic [4:0] M_LIT_TRUE  = 5'd20;
  localparam logic [4:0] M_LIT_FALSE = 5'd21;
  localparam logic [4:0] M_LIT_NULL  = 5'd22;

  // events
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
  localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
  localparam logic [3:0] EV_ARR_OPEN  = 4'd3;
  localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
  localparam logic [3:0] EV_KEY_BYTE  = 4'd5;
  localparam logic [3:0] EV_KEY_END   = 4'd6;
  localparam logic [3:0] EV_STR_BYTE  = 4'd7;
  localparam logic [3:0] EV_STR_END   = 4'd8;
  localparam logic [3:0] EV_NUM_BYTE  = 4'd9;
  localparam logic [3:0] EV_NUM_END   = 4'd10;
  localparam logic [3:0] EV_TRUE      = 4'd11;
  localparam logic [3:0] EV_FALSE     = 4'd12;
  localparam logic [3:0] EV_NULL      = 4'd13;
  localparam logic [3:0] EV_DOC_OK    = 4'd14;
  localparam logic [3:0] EV_ERROR     = 4'd15;

  // error codes
  localparam logic [4:0] E_NONE       = 5'd0;
  localparam logic [4:0] E_TRAILING   = 5'd1;
  localparam logic [4:0] E_NESTING    = 5'd2;
  localparam logic [4:0] E_EOF        = 5'd3;
  localparam logic [4:0] E_EXP_VALUE  = 5'd4;
  localparam logic [4:0] E_EXP_KEY    = 5'd5;
  localparam logic [4:0] E_EXP_COLON  = 5'd6;
  localparam logic [4:0] E_EXP_OBJSEP = 5'd7;
  localparam logic [4:0] E_EXP_ARRSEP = 5'd8;
  localparam logic [4:0] E_TRUNC_UNI  = 5'd9;
  localparam logic [4:0] E_BAD_UNI    = 5'd10;
  localparam logic [4:0] E_CTRL_CHAR  = 5'd11;
  localparam logic [4:0] E_TRUNC_ESC  = 5'd12;
  localparam logic [4:0] E_MISS_LOW   = 5'd13;
  localparam logic [4:0] E_BAD_LOW    = 5'd14;
  localparam logic [4:0] E_UNEXP_LOW  = 5'd15;
  localparam logic [4:0] E_UNK_ESC    = 5'd16;
  localparam logic [4:0] E_UNTERM_STR = 5'd17;
  localparam logic [4:0] E_TRUNC_NUM  = 5'd18;
  localparam logic [4:0] E_BAD_NUM    = 5'd19;
  localparam logic [4:0] E_MISS_FRAC  = 5'd20;
  localparam logic [4:0] E_MISS_EXP   = 5'd21;
  localparam logic [4:0] E_BAD_LIT    = 5'd22;

  typedef struct packed {
    logic [4:0]  mode;
    logic [5:0]  level;
    logic [15:0] hex_acc;
    logic [9:0]  hi_sur;
    logic [2:0]  sub_pos;
    logic        in_key;
    logic [4:0]  err;
  } jsv_state_t;

  typedef struct packed {
    logic [3:0] ev;
    logic [7:0] data;
    logic [5:0] depth;
    logic [4:0] err;
  } jsv_res_t;

  function automatic jsv_res_t mk_res(logic [3:0] ev, logic [7:0] data,
                                      logic [5:0] depth, logic [4:0] err);
    jsv_res_t r;
    r.ev    = ev;
    r.data  = data;
    r.depth = depth;
    r.err   = err;
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // value in [3:0], 16 when not a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b >= "0" && b <= "9") v = 5'(b - 8'h30);
    else if (b >= "a" && b <= "f") v = 5'(b - 8'h57);
    else if (b >= "A" && b <= "F") v = 5'(b - 8'h37);
    return v;
  endfunction

  // expected literal character at a position
  function automatic logic [7:0] lit_char(logic [4:0] mode, logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (mode == M_LIT_TRUE) begin
      case (pos)
        3'd1: c = "r";
        3'd2: c = "u";
        3'd3: c = "e";
        default: c = 8'h00;
      endcase
    end else if (mode == M_LIT_FALSE) begin
      case (pos)
        3'd1: c = "a";
        3'd2: c = "l";
        3'd3: c = "s";
        3'd4: c = "e";
        default: c = 8'h00;
      endcase
    end else begin
      case (pos)
        3'd1: c = "u";
        3'd2: c = "l";
        3'd3: c = "l";
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

>>> src/jsv_in_if.sv
// jsv_in_if: input channel of the json stream validator
// depends on nothing
interface jsv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

>>> src/jsv_out_if.sv
// jsv_out_if: result channel of the json stream validator
// depends on nothing
interface jsv_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [7:0] out_byte;
  logic [5:0] nest_depth;
  logic [4:0] error_code;
  logic       last_of_run;

  modport source (output valid, event_res, out_byte, nest_depth, error_code, last_of_run,
                  input ready);
  modport sink (input valid, event_res, out_byte, nest_depth, error_code, last_of_run,
                output ready);
endinterface

>>> src/json_stream_validator.sv
// json_stream_validator: streaming json tokenizer and validator, top level
// depends on jsv_pkg, jsv_in_if, jsv_out_if and jsv_step
//
// channel | dir | payload                                              | transfer
// in_ch   | in  | kind, data_byte                                      | valid & ready
// out_ch  | out | event_res, out_byte, nest_depth, error_code, last_of_run | valid & ready
//
// each accepted item is decoded in the cycle it arrives; its zero to four
// results land in a small result buffer and leave one per cycle while out_ch.ready is high
// an item giving at most one result does not stall the input while out_ch.ready is high,
// so a byte a cycle flows; an item giving more results holds in_ch.ready low until its last result is leaving
// reset (rst_n low, synchronous) empties the buffer and returns the parser to
// expecting a top-level value; the container stack needs no reset
module json_stream_validator import jsv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  jsv_in_if.sink          in_ch,
  jsv_out_if.source       out_ch
);

  jsv_state_t             st_r, st_nxt;
  logic [STACK_SLOTS-1:0] stk_r, stk_nxt;   // bit 0 is the innermost container
  jsv_res_t               step_res [MAX_RES];
  logic [2:0]             step_cnt;

  jsv_res_t               buf_r [MAX_RES];
  logic [2:0]             cnt_r;            // results still waiting
  logic [1:0]             rd_r;             // next result to send

  logic in_fire, out_fire;

  jsv_step u_step (
    .st      (st_r),
    .stk     (stk_r),
    .kind    (in_ch.kind),
    .b       (in_ch.data_byte),
    .st_nxt  (st_nxt),
    .stk_nxt (stk_nxt),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  // take a new item once the buffer drains, including the cycle the last
  // waiting result leaves
  assign in_ch.ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (cnt_r != 3'd0);
  assign out_ch.event_res   = buf_r[rd_r].ev;
  assign out_ch.out_byte    = buf_r[rd_r].data;
  assign out_ch.nest_depth  = buf_r[rd_r].depth;
  assign out_ch.error_code  = buf_r[rd_r].err;
  assign out_ch.last_of_run = (cnt_r == 3'd1);

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: M_VALUE, default: '0};
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // container stack, a shift line
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stk_r <= stk_nxt;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      rd_r  <= 2'd0;
    end else if (in_fire) begin
      cnt_r <= step_cnt;
      rd_r  <= 2'd0;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 3'd1;
      rd_r  <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < MAX_RES; k++) buf_r[k] <= step_res[k];
    end
  end

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.level <= 6'(STACK_SLOTS))
    else $error("container level beyond stack size");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(MAX_RES))
    else $error("result count beyond buffer size");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.kind |=> st_r.level == 6'd0 && st_r.err == E_NONE
      && st_r.mode == M_VALUE)
    else $error("end item did not restart the parser");

  a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.kind |=> cnt_r != 3'd0)
    else $error("end item gave no result");
`endif

endmodule

>>> src/jsv_step.sv
// jsv_step: next-state and result logic for one input item
// depends on jsv_pkg
module jsv_step import jsv_pkg::*; (
  input  jsv_state_t             st,
  input  logic [STACK_SLOTS-1:0] stk,
  input  logic                   kind,
  input  logic [7:0]             b,
  output jsv_state_t             st_nxt,
  output logic [STACK_SLOTS-1:0] stk_nxt,
  output jsv_res_t               res [MAX_RES],
  output logic [2:0]             res_cnt
);

  always_comb begin : step_logic
    logic [2:0]  n;
    logic        do_after;
    logic        top_obj;
    logic [4:0]  hv;
    logic [15:0] acc;
    logic [20:0] cp;
    logic        do_utf8;
    logic [7:0]  ub [4];
    logic [2:0]  un;
    logic [3:0]  tev;
    logic [4:0]  code;
    logic [4:0]  m;
    logic [2:0]  lit_len;

    st_nxt   = st;
    stk_nxt  = stk;
    n        = 3'd0;
    do_after = 1'b0;
    do_utf8  = 1'b0;
    top_obj  = stk[0];
    cp       = '0;
    hv       = hex_val(b);
    acc      = {st.hex_acc[11:0], hv[3:0]};
    tev      = st.in_key ? EV_KEY_BYTE : EV_STR_BYTE;
    code     = E_NONE;
    m        = st.mode;
    lit_len  = (st.mode == M_LIT_FALSE) ? 3'd5 : 3'd4;
    for (int k = 0; k < 4; k++) ub[k] = 8'h00;
    un = 3'd0;
    for (int k = 0; k < MAX_RES; k++) res[k] = mk_res(4'd0, 8'h00, 6'd0, E_NONE);

    if (kind) begin
      // end of document
      code = st.err;
      if (code == E_NONE) begin
        if (m == M_N_ZERO || m == M_N_INT || m == M_N_FRAC || m == M_N_EXP) begin
          res[0] = mk_res(EV_NUM_END, 8'h00, st.level, E_NONE);
          n = 3'd1;
          m = M_AFTER;
        end
        case (m)
          M_AFTER: code = (st.level == 6'd0) ? E_NONE :
                          (stk[0] ? E_EXP_OBJSEP : E_EXP_ARRSEP);
          M_VALUE: code = E_EOF;
          M_OBJ_FIRST, M_OBJ_KEY: code = E_EXP_KEY;
          M_COLON: code = E_EXP_COLON;
          M_ARR_FIRST: code = (st.level > 6'(MAX_DEPTH)) ? E_NESTING : E_EOF;
          M_STR: code = E_UNTERM_STR;
          M_ESC: code = E_TRUNC_ESC;
          M_HEX_HI, M_HEX_LO: code = E_TRUNC_UNI;
          M_LOW_BS, M_LOW_U: code = E_MISS_LOW;
          M_N_SIGN: code = E_TRUNC_NUM;
          M_N_FRAC0: code = E_MISS_FRAC;
          M_N_EXP0, M_N_EXPS: code = E_MISS_EXP;
          default: code = E_BAD_LIT;
        endcase
      end
      st_nxt = '0;
      st_nxt.mode = M_VALUE;
      if (code != E_NONE) res[n[1:0]] = mk_res(EV_ERROR, 8'h00, 6'd0, code);
      else res[n[1:0]] = mk_res(EV_DOC_OK, 8'h00, 6'd0, E_NONE);
      n = n + 3'd1;
    end else if (st.err == E_NONE) begin
      case (st.mode)
        M_VALUE, M_ARR_FIRST: begin
          if (is_ws(b)) begin
          end else if (st.mode == M_ARR_FIRST && b == "]") begin
            st_nxt.level = st.level - 6'd1;
            stk_nxt = stk >> 1;
            res[0] = mk_res(EV_ARR_CLOSE, 8'h00, st_nxt.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_AFTER;
          end else if (st.mode == M_ARR_FIRST && st.level > 6'(MAX_DEPTH)) begin
            code = E_NESTING;
          end else if (b == "{" || b == "[") begin
            stk_nxt = {stk[STACK_SLOTS-2:0], (b == "{")};
            st_nxt.level = st.level + 6'd1;
            res[0] = mk_res((b == "{") ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'h00,
                            st_nxt.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = (b == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
          end else if (b == "\"") begin
            st_nxt.in_key = 1'b0;
            st_nxt.mode = M_STR;
          end else if (b == "t" || b == "f" || b == "n") begin
            st_nxt.sub_pos = 3'd1;
            st_nxt.mode = (b == "t") ? M_LIT_TRUE : ((b == "f") ? M_LIT_FALSE : M_LIT_NULL);
          end else if (b == "-" || is_digit(b)) begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = (b == "-") ? M_N_SIGN : ((b == "0") ? M_N_ZERO : M_N_INT);
          end else begin
            code = E_EXP_VALUE;
          end
        end
        M_AFTER: do_after = 1'b1;
        M_OBJ_FIRST, M_OBJ_KEY: begin
          if (is_ws(b)) begin
          end else if (b == "}" && st.mode == M_OBJ_FIRST) begin
            st_nxt.level = st.level - 6'd1;
            stk_nxt = stk >> 1;
            res[0] = mk_res(EV_OBJ_CLOSE, 8'h00, st_nxt.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_AFTER;
          end else if (b == "\"") begin
            st_nxt.in_key = 1'b1;
            st_nxt.mode = M_STR;
          end else begin
            code = E_EXP_KEY;
          end
        end
        M_COLON: begin
          if (is_ws(b)) begin
          end else if (b != ":") code = E_EXP_COLON;
          else if (st.level > 6'(MAX_DEPTH)) code = E_NESTING;
          else st_nxt.mode = M_VALUE;
        end
        M_STR: begin
          if (b == "\"") begin
            res[0] = mk_res(st.in_key ? EV_KEY_END : EV_STR_END, 8'h00, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = st.in_key ? M_COLON : M_AFTER;
            st_nxt.in_key = 1'b0;
          end else if (b < 8'h20) begin
            code = E_CTRL_CHAR;
          end else if (b == "\\") begin
            st_nxt.mode = M_ESC;
          end else begin
            res[0] = mk_res(tev, b, st.level, E_NONE);
            n = 3'd1;
          end
        end
        M_ESC: begin
          st_nxt.mode = M_STR;
          n = 3'd1;
          case (b)
            "\"", "\\", "/": res[0] = mk_res(tev, b, st.level, E_NONE);
            "b": res[0] = mk_res(tev, 8'h08, st.level, E_NONE);
            "f": res[0] = mk_res(tev, 8'h0c, st.level, E_NONE);
            "n": res[0] = mk_res(tev, 8'h0a, st.level, E_NONE);
            "r": res[0] = mk_res(tev, 8'h0d, st.level, E_NONE);
            "t": res[0] = mk_res(tev, 8'h09, st.level, E_NONE);
            "u": begin
              n = 3'd0;
              st_nxt.hex_acc = 16'h0000;
              st_nxt.sub_pos = 3'd0;
              st_nxt.mode = M_HEX_HI;
            end
            default: begin
              n = 3'd0;
              st_nxt.mode = M_ESC;
              code = E_UNK_ESC;
            end
          endcase
        end
        M_HEX_HI, M_HEX_LO: begin
          if (hv[4]) begin
            code = E_BAD_UNI;
          end else begin
            st_nxt.hex_acc = acc;
            st_nxt.sub_pos = st.sub_pos + 3'd1;
            if (st_nxt.sub_pos == 3'd4) begin
              if (st.mode == M_HEX_HI) begin
                if (acc[15:10] == 6'b110110) begin
                  st_nxt.hi_sur = acc[9:0];
                  st_nxt.mode = M_LOW_BS;
                end else if (acc[15:10] == 6'b110111) begin
                  code = E_UNEXP_LOW;
                end else begin
                  cp = {5'd0, acc};
                  do_utf8 = 1'b1;
                  st_nxt.mode = M_STR;
                end
              end else begin
                if (acc[15:10] != 6'b110111) begin
                  code = E_BAD_LOW;
                end else begin
                  cp = 21'h10000 + {1'b0, st.hi_sur, acc[9:0]};
                  do_utf8 = 1'b1;
                  st_nxt.mode = M_STR;
                end
              end
            end
          end
        end
        M_LOW_BS: begin
          if (b == "\\") st_nxt.mode = M_LOW_U;
          else code = E_MISS_LOW;
        end
        M_LOW_U: begin
          if (b == "u") begin
            st_nxt.hex_acc = 16'h0000;
            st_nxt.sub_pos = 3'd0;
            st_nxt.mode = M_HEX_LO;
          end else begin
            code = E_MISS_LOW;
          end
        end
        M_N_SIGN: begin
          if (is_digit(b)) begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = (b == "0") ? M_N_ZERO : M_N_INT;
          end else begin
            code = E_BAD_NUM;
          end
        end
        M_N_ZERO, M_N_INT, M_N_FRAC: begin
          if (is_digit(b) && st.mode != M_N_ZERO) begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
          end else if (b == "." && st.mode != M_N_FRAC) begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_N_FRAC0;
          end else if (b == "e" || b == "E") begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_N_EXP0;
          end else begin
            res[0] = mk_res(EV_NUM_END, 8'h00, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_AFTER;
            do_after = 1'b1;
          end
        end
        M_N_FRAC0: begin
          if (is_digit(b)) begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_N_FRAC;
          end else begin
            code = E_MISS_FRAC;
          end
        end
        M_N_EXP0, M_N_EXPS: begin
          if (is_digit(b)) begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_N_EXP;
          end else if ((b == "+" || b == "-") && st.mode == M_N_EXP0) begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_N_EXPS;
          end else begin
            code = E_MISS_EXP;
          end
        end
        M_N_EXP: begin
          if (is_digit(b)) begin
            res[0] = mk_res(EV_NUM_BYTE, b, st.level, E_NONE);
            n = 3'd1;
          end else begin
            res[0] = mk_res(EV_NUM_END, 8'h00, st.level, E_NONE);
            n = 3'd1;
            st_nxt.mode = M_AFTER;
            do_after = 1'b1;
          end
        end
        M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL: begin
          if (st.sub_pos >= lit_len || b != lit_char(st.mode, st.sub_pos)) begin
            code = E_BAD_LIT;
          end else begin
            st_nxt.sub_pos = st.sub_pos + 3'd1;
            if (st_nxt.sub_pos == lit_len) begin
              res[0] = mk_res((st.mode == M_LIT_TRUE) ? EV_TRUE :
                              ((st.mode == M_LIT_FALSE) ? EV_FALSE : EV_NULL),
                              8'h00, st.level, E_NONE);
              n = 3'd1;
              st_nxt.mode = M_AFTER;
            end
          end
        end
        default: code = E_EXP_VALUE;
      endcase

      // byte in the position after a value (also the byte that ended a number)
      if (do_after && !is_ws(b)) begin
        if (st.level == 6'd0) begin
          code = E_TRAILING;
        end else if (top_obj) begin
          if (b == "}") begin
            st_nxt.level = st.level - 6'd1;
            stk_nxt = stk >> 1;
            res[n[1:0]] = mk_res(EV_OBJ_CLOSE, 8'h00, st_nxt.level, E_NONE);
            n = n + 3'd1;
            st_nxt.mode = M_AFTER;
          end else if (b == ",") st_nxt.mode = M_OBJ_KEY;
          else code = E_EXP_OBJSEP;
        end else begin
          if (b == "]") begin
            st_nxt.level = st.level - 6'd1;
            stk_nxt = stk >> 1;
            res[n[1:0]] = mk_res(EV_ARR_CLOSE, 8'h00, st_nxt.level, E_NONE);
            n = n + 3'd1;
            st_nxt.mode = M_AFTER;
          end else if (b == ",") begin
            if (st.level > 6'(MAX_DEPTH)) code = E_NESTING;
            else st_nxt.mode = M_VALUE;
          end else begin
            code = E_EXP_ARRSEP;
          end
        end
      end

      // utf-8 encoding of a decoded code point
      if (do_utf8) begin
        if (cp <= 21'h7f) begin
          ub[0] = cp[7:0];
          un = 3'd1;
        end else if (cp <= 21'h7ff) begin
          ub[0] = 8'hc0 | {3'd0, cp[10:6]};
          ub[1] = 8'h80 | {2'd0, cp[5:0]};
          un = 3'd2;
        end else if (cp <= 21'hffff) begin
          ub[0] = 8'he0 | {4'd0, cp[15:12]};
          ub[1] = 8'h80 | {2'd0, cp[11:6]};
          ub[2] = 8'h80 | {2'd0, cp[5:0]};
          un = 3'd3;
        end else begin
          ub[0] = 8'hf0 | {5'd0, cp[20:18]};
          ub[1] = 8'h80 | {2'd0, cp[17:12]};
          ub[2] = 8'h80 | {2'd0, cp[11:6]};
          ub[3] = 8'h80 | {2'd0, cp[5:0]};
          un = 3'd4;
        end
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < un) res[k] = mk_res(tev, ub[k], st.level, E_NONE);
        end
        n = un;
      end

      if (code != E_NONE) begin
        st_nxt.err = code;
        res[n[1:0]] = mk_res(EV_ERROR, 8'h00, st_nxt.level, code);
        n = n + 3'd1;
      end
    end

    res_cnt = n;
  end

endmodule
